// File: hw/rtl/cdsp_pkg.sv
// Shared constants and types for the counter delta share block.
package cdsp_pkg;

  // Datapath sizing
  localparam int CHANNELS  = 4;
  localparam int COUNTER_W = 32;
  localparam int SHARE_W   = 10;
  localparam int PER_MILLE = 1000;

  // Derived widths
  localparam int TOTAL_W = COUNTER_W + $clog2(CHANNELS);
  localparam int PROD_W  = COUNTER_W + SHARE_W;
  localparam int DIV_W   = TOTAL_W + SHARE_W;
  localparam int STEP_W  = $clog2(SHARE_W);

  // Per-cycle commands from the sequencer to the lanes and the merge stage
  typedef struct packed {
    logic start;  // capture sample, form change
    logic mult;   // scale change, form total
    logic load;   // load dividend and aligned divisor
    logic step;   // one quotient bit
  } lane_ctl_t;

endpackage

// File: hw/rtl/cdsp_if.sv
// Channel interfaces for sample words and result words.
interface cdsp_in_if;
  import cdsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COUNTER_W-1:0] count_0;
  logic [COUNTER_W-1:0] count_1;
  logic [COUNTER_W-1:0] count_2;
  logic [COUNTER_W-1:0] count_3;

  modport source (output valid, count_0, count_1, count_2, count_3, input ready);
  modport sink   (input valid, count_0, count_1, count_2, count_3, output ready);
endinterface

interface cdsp_out_if;
  import cdsp_pkg::*;

  logic               valid;
  logic               ready;
  logic [SHARE_W-1:0] share_0;
  logic [SHARE_W-1:0] share_1;
  logic [SHARE_W-1:0] share_2;
  logic [SHARE_W-1:0] share_3;
  logic [TOTAL_W-1:0] change_sum;

  modport source (output valid, share_0, share_1, share_2, share_3, change_sum,
                  input ready);
  modport sink   (input valid, share_0, share_1, share_2, share_3, change_sum,
                  output ready);
endinterface

// File: hw/rtl/cdsp_lane.sv
// One channel lane: counter change, per-mille scaling and bit-serial division.
module cdsp_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdsp_pkg::lane_ctl_t           ctl,
  input  logic [cdsp_pkg::COUNTER_W-1:0] count_in,
  input  logic [cdsp_pkg::TOTAL_W-1:0]   total,
  input  logic [cdsp_pkg::DIV_W-1:0]     dvs,
  output logic [cdsp_pkg::COUNTER_W-1:0] delta,
  output logic [cdsp_pkg::SHARE_W-1:0]   share
);
  import cdsp_pkg::*;

  logic [COUNTER_W-1:0] prev_r;
  logic [COUNTER_W-1:0] delta_r;
  logic [PROD_W-1:0]    prod_r;
  logic [DIV_W-1:0]     rem_r;
  logic [SHARE_W-1:0]   quot_r;
  logic                 fits;

  // Hold the previous sample; reset value is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ctl.start) begin
      prev_r <= count_in;
    end
  end

  // Divisor fits under the partial remainder at this bit position
  assign fits = (rem_r >= dvs);

  // Change modulo the counter width, scale, then restoring division
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      delta_r <= count_in - prev_r;
    end
    if (ctl.mult) begin
      prod_r <= PROD_W'(delta_r) * PROD_W'(PER_MILLE);
    end
    if (ctl.load) begin
      rem_r  <= DIV_W'(prod_r) + DIV_W'(total >> 1);
      quot_r <= '0;
    end else if (ctl.step) begin
      if (fits) begin
        rem_r <= rem_r - dvs;
      end
      quot_r <= {quot_r[SHARE_W-2:0], fits};
    end
  end

  assign delta = delta_r;
  assign share = quot_r;

endmodule

// File: hw/rtl/cdsp_merge.sv
// Merge stage: sums the lane changes and steps the shared aligned divisor.
module cdsp_merge (
  input  logic                                          clk,
  input  cdsp_pkg::lane_ctl_t                           ctl,
  input  logic [cdsp_pkg::CHANNELS-1:0][cdsp_pkg::COUNTER_W-1:0] delta,
  output logic [cdsp_pkg::TOTAL_W-1:0]                  total,
  output logic [cdsp_pkg::DIV_W-1:0]                    dvs
);
  import cdsp_pkg::*;

  logic [TOTAL_W-1:0] sum;
  logic [TOTAL_W-1:0] total_r;
  logic [DIV_W-1:0]   dvs_r;

  // Add the lane changes
  always_comb begin
    sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sum = sum + TOTAL_W'(delta[i]);
    end
  end

  // Force a zero total to one; align divisor to the top quotient bit, then shift down
  always_ff @(posedge clk) begin
    if (ctl.mult) begin
      total_r <= (sum == '0) ? TOTAL_W'(1) : sum;
    end
    if (ctl.load) begin
      dvs_r <= DIV_W'(total_r) << (SHARE_W - 1);
    end else if (ctl.step) begin
      dvs_r <= dvs_r >> 1;
    end
  end

  assign total = total_r;
  assign dvs   = dvs_r;

endmodule

// File: hw/rtl/counter_delta_share_per_mille_unit.sv
// Top level: sequencer, channel lanes, merge stage and result register.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        count_0..count_3 (32 b each)
//   out_ch   out  valid/ready        share_0..share_3 (10 b), change_sum (34 b)
//
// One sample passes from acceptance to a loaded result register in order:
// change at acceptance, scale/sum, load, 10 quotient steps of the lane
// dividers, then the done state; input is ready again once done loads the result.
// A finished result waits in the output register; a new sample is taken
// while it waits, and the next result is held back until that one is taken.
// rst_n clears the stored previous sample, holds input ready low, drops valids.
module counter_delta_share_per_mille_unit (
  input  logic      clk,
  input  logic      rst_n,
  cdsp_in_if.sink   in_ch,
  cdsp_out_if.source out_ch
);
  import cdsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                              state_r;
  logic [STEP_W-1:0]                   step_r;
  logic                                out_valid_r;
  logic [CHANNELS-1:0][SHARE_W-1:0]    share_out_r;
  logic [TOTAL_W-1:0]                  total_out_r;

  lane_ctl_t                           ctl;
  logic [CHANNELS-1:0][COUNTER_W-1:0]  count_in;
  logic [CHANNELS-1:0][COUNTER_W-1:0]  delta;
  logic [CHANNELS-1:0][SHARE_W-1:0]    share;
  logic [TOTAL_W-1:0]                  total;
  logic [DIV_W-1:0]                    dvs;
  logic                                in_fire;
  logic                                out_free;

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign count_in[0] = in_ch.count_0;
  assign count_in[1] = in_ch.count_1;
  assign count_in[2] = in_ch.count_2;
  assign count_in[3] = in_ch.count_3;

  // Decode lane commands from the state
  always_comb begin
    ctl.start = in_fire;
    ctl.mult  = (state_r == ST_SUM);
    ctl.load  = (state_r == ST_LOAD);
    ctl.step  = (state_r == ST_DIV);
  end

  // Channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    cdsp_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .count_in (count_in[g]),
      .total    (total),
      .dvs      (dvs),
      .delta    (delta[g]),
      .share    (share[g])
    );
  end

  cdsp_merge u_merge (
    .clk   (clk),
    .ctl   (ctl),
    .delta (delta),
    .total (total),
    .dvs   (dvs)
  );

  // Sequence one sample and hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result valid on load, drop it once taken
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          step_r  <= STEP_W'(SHARE_W - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            share_out_r <= share;
            total_out_r <= total;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.share_0    = share_out_r[0];
  assign out_ch.share_1    = share_out_r[1];
  assign out_ch.share_2    = share_out_r[2];
  assign out_ch.share_3    = share_out_r[3];
  assign out_ch.change_sum = total_out_r;

`ifndef ASSERT_OFF
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word appeared outside the done state");

  a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (share_out_r[0] <= SHARE_W'(PER_MILLE)) &&
                    (share_out_r[1] <= SHARE_W'(PER_MILLE)) &&
                    (share_out_r[2] <= SHARE_W'(PER_MILLE)) &&
                    (share_out_r[3] <= SHARE_W'(PER_MILLE)))
    else $error("share above one thousand");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (total_out_r != '0))
    else $error("zero total on result word");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (step_r <= STEP_W'(SHARE_W - 1)))
    else $error("division step counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(total_out_r))
    else $error("pending result word overwritten");
`endif

endmodule
